// File: sv/mau_pkg.sv
// shared constants, operation codes and controller commands for the modular arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package mau_pkg;
   localparam int Width = 16;
   localparam int CntW = 5;  // holds 0..Width-1 and Width

   localparam logic [Width-1:0] ModulusReset = Width'(65521);

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_POW = 3'd3;
   localparam logic [2:0] OP_INV = 3'd4;
   localparam logic [2:0] OP_DIV = 3'd5;

   // datapath commands
   localparam logic [3:0] CMD_NONE     = 4'd0;
   localparam logic [3:0] CMD_LOAD     = 4'd1;  // capture operands, clear remainders
   localparam logic [3:0] CMD_REDUCE   = 4'd2;  // one bit of a mod m and b mod m
   localparam logic [3:0] CMD_ADDSUB   = 4'd3;  // res = (a +/- b) mod m
   localparam logic [3:0] CMD_MUL_INIT = 4'd4;  // start x*y mod m
   localparam logic [3:0] CMD_MUL_STEP = 4'd5;  // one bit of shift-add multiply
   localparam logic [3:0] CMD_DIV_INIT = 4'd6;  // start r0 / r1
   localparam logic [3:0] CMD_DIV_STEP = 4'd7;  // one bit of restoring divide
   localparam logic [3:0] CMD_EUC_UPD  = 4'd8;  // Euclid update with quotient
   localparam logic [3:0] CMD_EUC_INIT = 4'd9;
   localparam logic [3:0] CMD_TMUL_STEP = 4'd10; // one bit of q*t1 mod m
   localparam logic [3:0] CMD_POW_INIT = 4'd11;
   localparam logic [3:0] CMD_POW_SHIFT = 4'd12;
   localparam logic [3:0] CMD_INV_OUT  = 4'd13; // res = t0

   // multiplier operand selects
   localparam logic [1:0] MSEL_AB   = 2'd0;  // a * b
   localparam logic [1:0] MSEL_RB   = 2'd1;  // res * base
   localparam logic [1:0] MSEL_BB   = 2'd2;  // base * base
   localparam logic [1:0] MSEL_AINV = 2'd3;  // a * inverse

   typedef struct packed {
      logic [3:0] cmd;
      logic [1:0] msel;
      logic       sub;        // addsub selects subtract
      logic       mul_to_res; // multiply result written to res
   } mau_cmd_type;

   typedef struct packed {
      logic       mod_small;  // modulus is 0 or 1
      logic       mod_zero;
      logic       b_zero;
      logic       e_zero;     // exponent exhausted
      logic       e_lsb;
      logic       cnt_done;
      logic       r1_zero;
      logic       r0_one;
      logic       inv_zero;
   } mau_stat_type;
endpackage

// File: sv/modular_arithmetic_unit.sv
// top level of the modular arithmetic unit: modulus register, controller, datapath
// depends on mau_pkg, mau_controller, mau_datapath
`timescale 1ns / 1ps
// operands are first reduced mod m; then add/sub, a serial multiply, power (up to
// two serial multiplies per exponent bit) or inverse/divide (one serial divide and one
// serial multiply per euclid step, at most 22 steps) produces the result
// one item at a time; busy stays high through the result strobe, next transfer after it
// reset restores modulus 65521 and returns the controller to idle
// results go out on rsp_valid for one cycle; the receiver cannot stall
module modular_arithmetic_unit
   import mau_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_operation,
   input  logic [Width-1:0] req_operand_a,
   input  logic [Width-1:0] req_operand_b,
   output logic             rsp_valid,
   output logic [Width-1:0] rsp_result,
   output logic             rsp_no_solution,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [Width-1:0] csr_modulus
);
   logic [Width-1:0] modulus_ff;
   mau_cmd_type      ctl;
   mau_stat_type     stat;
   logic [Width-1:0] res;
   logic             done, fail, clear, cbusy;
   logic [Width-1:0] inv_res;

   // modulus register, written on a csr transfer
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) modulus_ff <= ModulusReset;
      else if (csr_valid) modulus_ff <= csr_modulus;
   end

   mau_controller u_ctrl (
      .clock, .reset, .start, .op(req_operation),
      .stat, .ctl, .busy(cbusy), .done, .fail, .clear
   );

   mau_datapath u_dp (
      .clock, .modulus(modulus_ff), .in_a(req_operand_a), .in_b(req_operand_b),
      .ctl, .stat, .res_out(res)
   );

   assign inv_res = res;
   assign busy            = cbusy;
   assign rsp_valid       = done;
   // zero result on no solution, zero modulus and unused codes
   assign rsp_result      = (fail | clear) ? '0 : inv_res;
   assign rsp_no_solution = done & fail;
endmodule

// File: sv/mau_datapath.sv
// datapath of the modular arithmetic unit: operand registers, serial multiply, divide, euclid
// depends on mau_pkg
`timescale 1ns / 1ps
module mau_datapath
   import mau_pkg::*;
(
   input  logic              clock,
   input  logic [Width-1:0]  modulus,
   input  logic [Width-1:0]  in_a,
   input  logic [Width-1:0]  in_b,
   input  mau_cmd_type       ctl,
   output mau_stat_type      stat,
   output logic [Width-1:0]  res_out
);
   // working registers
   logic [Width-1:0] a_ff, a_in, b_ff, b_in, res_ff, res_in, base_ff, base_in;
   logic [Width-1:0] e_ff, e_in;
   logic [Width-1:0] acc_ff, acc_in, mx_ff, mx_in, my_ff, my_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [Width-1:0] r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [Width-1:0] q_ff, q_in, rem_ff, rem_in;

   logic [Width:0]   dbl, sum, dsh, ra, rb;
   logic [Width-1:0] dbl_r, sum_r, add_r, sub_r, tnew;
   logic [Width:0]   a_sum;

   // modular add of two residues
   function automatic logic [Width-1:0] madd(input logic [Width-1:0] x, y, m);
      logic [Width:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[Width-1:0];
   endfunction

   always_comb begin
      a_in = a_ff; b_in = b_ff; res_in = res_ff; base_in = base_ff; e_in = e_ff;
      acc_in = acc_ff; mx_in = mx_ff; my_in = my_ff; cnt_in = cnt_ff;
      r0_in = r0_ff; r1_in = r1_ff; t0_in = t0_ff; t1_in = t1_ff;
      q_in = q_ff; rem_in = rem_ff;
      dbl = '0; sum = '0; dbl_r = '0; sum_r = '0; dsh = '0; tnew = '0;
      ra = '0; rb = '0;
      a_sum = {1'b0, a_ff} + {1'b0, b_ff};
      add_r = madd(a_ff, b_ff, modulus);
      sub_r = (a_ff >= b_ff) ? a_ff - b_ff : a_ff + (modulus - b_ff);
      unique case (ctl.cmd)
         CMD_LOAD: begin
            a_in = in_a; b_in = in_b; e_in = in_b; res_in = '0;
            acc_in = '0; rem_in = '0; cnt_in = '0;
         end
         CMD_REDUCE: begin
            // msb-first remainder of a (in acc) and b (in rem), one bit per cycle
            ra = {acc_ff, a_ff[Width-1]};
            rb = {rem_ff, b_ff[Width-1]};
            if (ra >= {1'b0, modulus}) ra = ra - {1'b0, modulus};
            if (rb >= {1'b0, modulus}) rb = rb - {1'b0, modulus};
            acc_in = ra[Width-1:0];
            rem_in = rb[Width-1:0];
            a_in   = {a_ff[Width-2:0], 1'b0};
            b_in   = {b_ff[Width-2:0], 1'b0};
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(Width - 1)) begin
               a_in = ra[Width-1:0];
               b_in = rb[Width-1:0];
            end
         end
         CMD_ADDSUB: res_in = ctl.sub ? sub_r : add_r;
         CMD_MUL_INIT: begin
            acc_in = '0; cnt_in = '0;
            unique case (ctl.msel)
               MSEL_AB:   begin mx_in = a_ff;    my_in = b_ff;    end
               MSEL_RB:   begin mx_in = res_ff;  my_in = base_ff; end
               MSEL_BB:   begin mx_in = base_ff; my_in = base_ff; end
               MSEL_AINV: begin mx_in = a_ff;    my_in = t0_ff;   end
               default:   begin mx_in = a_ff;    my_in = b_ff;    end
            endcase
         end
         CMD_MUL_STEP, CMD_TMUL_STEP: begin
            // msb-first double and add
            dbl   = {acc_ff, 1'b0};
            dbl_r = (dbl >= {1'b0, modulus}) ? Width'(dbl - {1'b0, modulus})
                                             : dbl[Width-1:0];
            sum   = {1'b0, dbl_r} + (my_ff[Width-1] ? {1'b0, mx_ff} : '0);
            sum_r = (sum >= {1'b0, modulus}) ? Width'(sum - {1'b0, modulus})
                                             : sum[Width-1:0];
            acc_in = sum_r;
            my_in  = {my_ff[Width-2:0], 1'b0};
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(Width - 1)) begin
               if (ctl.cmd == CMD_TMUL_STEP) begin
                  // t_new = t0 - q*t1 mod m
                  tnew  = (t0_ff >= sum_r) ? t0_ff - sum_r : t0_ff + (modulus - sum_r);
                  t0_in = t1_ff; t1_in = tnew;
               end else if (ctl.mul_to_res) res_in = sum_r;
               else base_in = sum_r;
            end
         end
         CMD_POW_INIT: begin
            // zero exponent gives 1 for any nonzero modulus
            res_in = Width'(1); base_in = a_ff;
            if (modulus == Width'(1) && e_ff != '0) res_in = '0;
         end
         CMD_POW_SHIFT: e_in = e_ff >> 1;
         CMD_EUC_INIT: begin
            r0_in = modulus; r1_in = ctl.msel == MSEL_AB ? b_ff : a_ff;
            t0_in = '0; t1_in = Width'(1);
         end
         CMD_DIV_INIT: begin q_in = r0_ff; rem_in = '0; cnt_in = '0; end
         CMD_DIV_STEP: begin
            dsh = {rem_ff, q_ff[Width-1]};
            if (dsh >= {1'b0, r1_ff}) begin
               rem_in = Width'(dsh - {1'b0, r1_ff});
               q_in   = {q_ff[Width-2:0], 1'b1};
            end else begin
               rem_in = dsh[Width-1:0];
               q_in   = {q_ff[Width-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CntW'(1);
         end
         CMD_EUC_UPD: begin
            // remainders advance; q*t1 mod m is then formed serially
            r0_in = r1_ff; r1_in = rem_ff;
            mx_in = t1_ff; my_in = (q_ff >= modulus) ? q_ff - modulus : q_ff;
            acc_in = '0; cnt_in = '0;
         end
         CMD_INV_OUT: res_in = t0_ff;
         default: ;
      endcase
      if (ctl.cmd == CMD_ADDSUB && a_sum == '0) res_in = res_in;
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; res_ff <= res_in; base_ff <= base_in; e_ff <= e_in;
      acc_ff <= acc_in; mx_ff <= mx_in; my_ff <= my_in; cnt_ff <= cnt_in;
      r0_ff <= r0_in; r1_ff <= r1_in; t0_ff <= t0_in; t1_ff <= t1_in;
      q_ff <= q_in; rem_ff <= rem_in;
   end

   always_comb begin
      stat.mod_zero  = modulus == '0;
      stat.mod_small = modulus < Width'(2);
      stat.b_zero    = b_ff == '0;
      stat.e_zero    = e_ff == '0;
      stat.e_lsb     = e_ff[0];
      stat.cnt_done  = cnt_ff == CntW'(Width);
      stat.r1_zero   = r1_ff == '0;
      stat.r0_one    = r0_ff == Width'(1);
      stat.inv_zero  = t0_ff == '0;
   end

   // the result register drives the output directly
   assign res_out = res_ff;
endmodule

// File: sv/mau_controller.sv
// controller state machine of the modular arithmetic unit
// depends on mau_pkg
`timescale 1ns / 1ps
module mau_controller
   import mau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [2:0]   op,
   input  mau_stat_type stat,
   output mau_cmd_type  ctl,
   output logic         busy,
   output logic         done,
   output logic         fail,
   output logic         clear
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RED    = 4'd1;
   localparam logic [3:0] S_DISP   = 4'd2;
   localparam logic [3:0] S_MUL    = 4'd3;
   localparam logic [3:0] S_PLOOP  = 4'd4;
   localparam logic [3:0] S_PSQ    = 4'd5;
   localparam logic [3:0] S_EUC    = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_TMUL   = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;
   localparam logic [3:0] S_PMUL   = 4'd10;
   localparam logic [3:0] S_DIVDIV = 4'd11;
   localparam logic [3:0] S_EUCEND = 4'd12;
   localparam logic [3:0] S_ZERO   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       fail_ff, fail_in, clr_ff, clr_in;

   always_comb begin
      state_in = state_ff; op_in = op_ff; fail_in = fail_ff; clr_in = clr_ff;
      ctl = '0; done = 1'b0;
      unique case (state_ff)
         S_IDLE: if (start) begin
            ctl.cmd = CMD_LOAD; op_in = op; fail_in = 1'b0; clr_in = 1'b0;
            state_in = S_RED;
         end
         S_RED: begin
            ctl.cmd = CMD_REDUCE;
            if (stat.mod_zero) begin
               fail_in = (op_ff == OP_INV) || (op_ff == OP_DIV);
               clr_in = 1'b1; state_in = S_DONE;
            end else if (stat.cnt_done) begin
               ctl.cmd = CMD_NONE; state_in = S_DISP;
            end
         end
         S_DISP: begin
            priority if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               ctl.cmd = CMD_ADDSUB; ctl.sub = op_ff == OP_SUB; state_in = S_DONE;
            end else if (op_ff == OP_MUL) begin
               ctl.cmd = CMD_MUL_INIT; ctl.msel = MSEL_AB; state_in = S_MUL;
            end else if (op_ff == OP_POW) begin
               ctl.cmd = CMD_POW_INIT; state_in = S_PLOOP;
            end else if (op_ff == OP_INV || op_ff == OP_DIV) begin
               ctl.cmd = CMD_EUC_INIT;
               ctl.msel = (op_ff == OP_DIV) ? MSEL_AB : MSEL_RB;
               if (stat.mod_small) begin
                  fail_in = 1'b1; clr_in = 1'b1; state_in = S_DONE;
               end else state_in = S_EUC;
            end else begin
               clr_in = 1'b1; state_in = S_DONE;
            end
         end
         S_MUL: begin
            ctl.cmd = CMD_MUL_STEP; ctl.mul_to_res = 1'b1;
            if (stat.cnt_done) begin ctl.cmd = CMD_NONE; state_in = S_DONE; end
         end
         S_PLOOP: begin
            if (stat.e_zero) state_in = S_DONE;
            else if (stat.e_lsb) begin
               ctl.cmd = CMD_MUL_INIT; ctl.msel = MSEL_RB; state_in = S_PMUL;
            end else begin
               ctl.cmd = CMD_MUL_INIT; ctl.msel = MSEL_BB; state_in = S_PSQ;
            end
         end
         S_PMUL: begin
            ctl.cmd = CMD_MUL_STEP; ctl.mul_to_res = 1'b1;
            if (stat.cnt_done) begin
               ctl.cmd = CMD_MUL_INIT; ctl.msel = MSEL_BB; state_in = S_PSQ;
            end
         end
         S_PSQ: begin
            ctl.cmd = CMD_MUL_STEP;
            if (stat.cnt_done) begin ctl.cmd = CMD_POW_SHIFT; state_in = S_PLOOP; end
         end
         S_EUC: begin
            if (stat.r1_zero) state_in = S_EUCEND;
            else begin ctl.cmd = CMD_DIV_INIT; state_in = S_DIV; end
         end
         S_DIV: begin
            ctl.cmd = CMD_DIV_STEP;
            if (stat.cnt_done) begin ctl.cmd = CMD_EUC_UPD; state_in = S_TMUL; end
         end
         S_TMUL: begin
            ctl.cmd = CMD_TMUL_STEP;
            if (stat.cnt_done) begin ctl.cmd = CMD_NONE; state_in = S_EUC; end
         end
         S_EUCEND: begin
            if (!stat.r0_one || stat.inv_zero) begin
               fail_in = 1'b1; clr_in = 1'b1; state_in = S_DONE;
            end else if (op_ff == OP_DIV) begin
               ctl.cmd = CMD_MUL_INIT; ctl.msel = MSEL_AINV; state_in = S_MUL;
            end else state_in = S_DIVDIV;
         end
         S_DIVDIV: begin
            // inverse: copy t0 into the result
            ctl.cmd = CMD_INV_OUT; state_in = S_ZERO;
         end
         S_ZERO: state_in = S_DONE;
         S_DONE: begin done = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; op_ff <= OP_ADD; fail_ff <= 1'b0; clr_ff <= 1'b0;
      end else begin
         state_ff <= state_in; op_ff <= op_in; fail_ff <= fail_in; clr_ff <= clr_in;
      end
   end

   assign busy  = state_ff != S_IDLE;
   assign fail  = fail_ff;
   assign clear = clr_ff;
endmodule
